### hw/rtl/bac_pkg.sv
// bac_pkg: shared types and constants of the bit-sliced add-rotate-xor block cipher
// item structs, control word, status struct, register indexes, byte shuffle table
// no dependencies
`timescale 1ns / 1ps

package bac_pkg;

  localparam int NumBytes = 16;
  localparam int PcWidth  = 4;

  localparam logic [7:0] RoundsReset = 8'd10;

  typedef enum logic [1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_ROUND_CNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WHITEN,
    OP_ENC_PERM,
    OP_MIX_ENC,
    OP_XSUM_ROT,
    OP_MIX_DEC,
    OP_DEC_PERM,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ROUND,
    C_DEC,
    C_PAIR_MORE,
    C_ROUND_MORE
  } cond_t;

  typedef struct packed {
    op_t                 op;
    cond_t               cond;
    logic [PcWidth-1:0]  target;
  } ctrl_word_t;

  typedef struct packed {
    logic is_dec;
    logic round_zero;
    logic pair_last;
  } dp_status_t;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_low;
    logic [63:0] block_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } out_item_t;

  // forward shuffle: byte i moves to FWD_DEST[i]
  localparam logic [3:0] FWD_DEST [NumBytes] = '{
    4'd7, 4'd12, 4'd14, 4'd9, 4'd2, 4'd1, 4'd5, 4'd15,
    4'd11, 4'd6, 4'd13, 4'd0, 4'd4, 4'd8, 4'd10, 4'd3
  };

endpackage

### hw/rtl/bac_ucode_rom.sv
// bac_ucode_rom: microcode program of the cipher sequencer
// one control word per step, indexed by the step counter; uses bac_pkg
`timescale 1ns / 1ps

module bac_ucode_rom
  import bac_pkg::*;
(
  input  logic [PcWidth-1:0] pc,
  output ctrl_word_t         word
);

  localparam logic [PcWidth-1:0] PcEncRound = PcWidth'(2);
  localparam logic [PcWidth-1:0] PcEncMix   = PcWidth'(3);
  localparam logic [PcWidth-1:0] PcDecRound = PcWidth'(6);
  localparam logic [PcWidth-1:0] PcDecMix   = PcWidth'(7);
  localparam logic [PcWidth-1:0] PcFinal    = PcWidth'(9);
  localparam logic [PcWidth-1:0] PcZero     = '0;

  always_comb begin
    unique case (pc)
      PcWidth'(0):  word = '{op: OP_WHITEN,   cond: C_NO_ROUND,   target: PcFinal};
      PcWidth'(1):  word = '{op: OP_NOP,      cond: C_DEC,        target: PcDecRound};
      PcWidth'(2):  word = '{op: OP_ENC_PERM, cond: C_NONE,       target: PcZero};
      PcWidth'(3):  word = '{op: OP_MIX_ENC,  cond: C_PAIR_MORE,  target: PcEncMix};
      PcWidth'(4):  word = '{op: OP_NOP,      cond: C_ROUND_MORE, target: PcEncRound};
      PcWidth'(5):  word = '{op: OP_NOP,      cond: C_ALWAYS,     target: PcFinal};
      PcWidth'(6):  word = '{op: OP_XSUM_ROT, cond: C_NONE,       target: PcZero};
      PcWidth'(7):  word = '{op: OP_MIX_DEC,  cond: C_PAIR_MORE,  target: PcDecMix};
      PcWidth'(8):  word = '{op: OP_DEC_PERM, cond: C_ROUND_MORE, target: PcDecRound};
      PcWidth'(9):  word = '{op: OP_WHITEN,   cond: C_NONE,       target: PcZero};
      PcWidth'(10): word = '{op: OP_DONE,     cond: C_NONE,       target: PcZero};
      default:      word = '{op: OP_NOP,      cond: C_NONE,       target: PcZero};
    endcase
  end

endmodule

### hw/rtl/bac_sequencer.sv
// bac_sequencer: step counter, busy flag and conditional jumps over the microcode
// instantiates bac_ucode_rom; uses bac_pkg
`timescale 1ns / 1ps

module bac_sequencer
  import bac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  dp_status_t status,
  output ctrl_word_t ctrl,
  output logic       busy
);

  logic [PcWidth-1:0] pc_r, pc_nxt;
  logic               busy_r, busy_nxt;
  ctrl_word_t         rom_word;
  logic               jump;

  bac_ucode_rom u_rom (
    .pc   (pc_r),
    .word (rom_word)
  );

  always_comb begin
    ctrl = rom_word;
    if (!busy_r) begin
      ctrl = '{op: OP_NOP, cond: C_NONE, target: '0};
    end
  end

  always_comb begin
    unique case (ctrl.cond)
      C_NONE:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_ROUND:   jump = status.round_zero;
      C_DEC:        jump = status.is_dec;
      C_PAIR_MORE:  jump = !status.pair_last;
      C_ROUND_MORE: jump = !status.round_zero;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (load) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      pc_nxt = jump ? ctrl.target : pc_r + PcWidth'(1);
      if (ctrl.op == OP_DONE) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

  a_load_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && pc_r == '0))
    else $error("load did not restart the program");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ctrl.op == OP_DONE) |=> !busy_r)
    else $error("busy held after done step");

  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !load) |=> !busy_r)
    else $error("sequencer left idle without a load");

endmodule

### hw/rtl/bac_datapath.sv
// bac_datapath: byte state, running xor sum, pair and round counters, one mix unit
// state rotates one byte per mix so the mix always works on bytes 14 and 15; uses bac_pkg
`timescale 1ns / 1ps

module bac_datapath
  import bac_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  in_item_t     in_item,
  input  logic [127:0] key,
  input  logic [7:0]   round_count,
  input  ctrl_word_t   ctrl,
  output dp_status_t   status,
  output logic         out_valid,
  output out_item_t    out_item
);

  logic [7:0] st_r   [NumBytes];
  logic [7:0] st_nxt [NumBytes];
  logic [7:0] enc_p  [NumBytes];
  logic [7:0] enc_t  [NumBytes];
  logic [7:0] dec_a  [NumBytes];
  logic [7:0] dec_b  [NumBytes];
  logic [7:0] dec_p  [NumBytes];
  logic [7:0] run_r, run_nxt;
  logic [7:0] enc_xsum, st_xsum;
  logic [3:0] pair_r, pair_nxt;
  logic [7:0] rnd_r, rnd_nxt;
  logic       dec_r;
  logic       out_valid_r;
  out_item_t  out_r;

  logic [7:0] mix_l, mix_r, kb, rest;
  logic [7:0] enc_r1, enc_l1, enc_l2;
  logic [7:0] dec_l1, dec_l2, dec_r1;

  // forward bit layer then forward shuffle
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        enc_t[r][c] = st_r[c][r];
      end
      enc_t[r+8] = {st_r[r+8][0], st_r[r+8][7:1]};
    end
    for (int i = 0; i < NumBytes; i++) begin
      enc_p[FWD_DEST[i]] = enc_t[i];
    end
    enc_xsum = '0;
    for (int i = 0; i < NumBytes; i++) begin
      enc_xsum = enc_xsum ^ enc_p[i];
    end
  end

  // undo rotation, inverse shuffle, inverse bit layer
  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      dec_a[i] = st_r[(i + NumBytes - 1) % NumBytes];
    end
    for (int i = 0; i < NumBytes; i++) begin
      dec_b[i] = dec_a[FWD_DEST[i]];
    end
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        dec_p[r][c] = dec_b[c][r];
      end
      dec_p[r+8] = {dec_b[r+8][6:0], dec_b[r+8][7]};
    end
    st_xsum = '0;
    for (int i = 0; i < NumBytes; i++) begin
      st_xsum = st_xsum ^ st_r[i];
    end
  end

  // add-rotate-xor mix on bytes 14 and 15
  assign mix_l  = st_r[14];
  assign mix_r  = st_r[15];
  assign kb     = key[{pair_r, 3'b000} +: 8];
  assign rest   = run_r ^ mix_l ^ mix_r;
  assign enc_r1 = mix_r + rest + kb;
  assign enc_l1 = mix_l + {4'b0000, enc_r1[7:4]};
  assign enc_l2 = enc_l1 ^ {enc_r1[2:0], enc_r1[7:3]};
  assign dec_l1 = mix_l ^ {mix_r[2:0], mix_r[7:3]};
  assign dec_l2 = dec_l1 - {4'b0000, mix_r[7:4]};
  assign dec_r1 = mix_r - rest - kb;

  always_comb begin
    st_nxt   = st_r;
    run_nxt  = run_r;
    pair_nxt = pair_r;
    rnd_nxt  = rnd_r;
    unique case (ctrl.op) inside
      OP_WHITEN: begin
        for (int i = 0; i < NumBytes; i++) begin
          st_nxt[i] = st_r[i] ^ key[8*i +: 8];
        end
      end
      OP_ENC_PERM: begin
        st_nxt   = enc_p;
        run_nxt  = enc_xsum;
        pair_nxt = 4'd15;
        rnd_nxt  = rnd_r - 8'd1;
      end
      OP_MIX_ENC: begin
        for (int j = 1; j < NumBytes - 1; j++) begin
          st_nxt[j] = st_r[j-1];
        end
        st_nxt[0]  = enc_r1;
        st_nxt[15] = enc_l2;
        run_nxt    = rest ^ enc_l2 ^ enc_r1;
        pair_nxt   = pair_r - 4'd1;
      end
      OP_XSUM_ROT: begin
        for (int j = 0; j < NumBytes; j++) begin
          st_nxt[j] = st_r[(j + 1) % NumBytes];
        end
        run_nxt  = st_xsum;
        pair_nxt = 4'd0;
        rnd_nxt  = rnd_r - 8'd1;
      end
      OP_MIX_DEC: begin
        for (int j = 0; j < NumBytes - 3; j++) begin
          st_nxt[j] = st_r[j+1];
        end
        st_nxt[13] = dec_l2;
        st_nxt[14] = dec_r1;
        st_nxt[15] = st_r[0];
        run_nxt    = rest ^ dec_l2 ^ dec_r1;
        pair_nxt   = pair_r + 4'd1;
      end
      OP_DEC_PERM: begin
        st_nxt = dec_p;
      end
      OP_NOP, OP_DONE: begin
      end
      default: begin
      end
    endcase
    if (load) begin
      for (int i = 0; i < 8; i++) begin
        st_nxt[i]   = in_item.block_low[8*i +: 8];
        st_nxt[i+8] = in_item.block_high[8*i +: 8];
      end
      rnd_nxt = round_count;
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    run_r  <= run_nxt;
    pair_r <= pair_nxt;
    rnd_r  <= rnd_nxt;
    if (load) begin
      dec_r <= in_item.operation;
    end
    if (ctrl.op == OP_DONE) begin
      for (int i = 0; i < 8; i++) begin
        out_r.result_low[8*i +: 8]  <= st_r[i];
        out_r.result_high[8*i +: 8] <= st_r[i+8];
      end
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctrl.op == OP_DONE);
    end
  end

  assign status.is_dec     = dec_r;
  assign status.round_zero = (rnd_r == 8'd0);
  assign status.pair_last  = dec_r ? (pair_r == 4'd15) : (pair_r == 4'd0);
  assign out_valid         = out_valid_r;
  assign out_item          = out_r;

  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DONE) |=> out_valid_r)
    else $error("done step gave no result strobe");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_pair_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_MIX_ENC && pair_r == 4'd0) |=> (pair_r == 4'd15))
    else $error("encrypt pair counter did not wrap");

endmodule

### hw/rtl/bitsliced_arx_block_cipher.sv
// bitsliced_arx_block_cipher: top level, configuration registers and channel ports
// instantiates bac_sequencer and bac_datapath; uses bac_pkg
//
//   port group   direction   handshake                     payload
//   in_          in          start / busy                  in_data (in_item_t)
//   out_         out         out_valid, one-cycle strobe   out_data (out_item_t)
//   cfg_         in          cfg_we                        cfg_index, cfg_wdata
//
// an encrypt round is one permute step, 16 mix steps on the single mix unit and one
// check step; a decrypt round is one xor-sum rotate step, 16 mix steps and one permute
// step that also checks; busy is high from the cycle after start until the done step
// reset is synchronous active low; keys reset to zero and round count to ten
// the result strobe cannot be stalled; start is ignored while busy
`timescale 1ns / 1ps

module bitsliced_arx_block_cipher
  import bac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] key_low_r, key_high_r;
  logic [7:0]  rnd_cfg_r;
  logic        load;
  ctrl_word_t  ctrl;
  dp_status_t  status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      rnd_cfg_r  <= RoundsReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_LOW:   key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH:  key_high_r <= cfg_wdata;
        CFG_ROUND_CNT: rnd_cfg_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign load = start && !busy;

  bac_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  bac_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .in_item     (in_data),
    .key         ({key_high_r, key_low_r}),
    .round_count (rnd_cfg_r),
    .ctrl        (ctrl),
    .status      (status),
    .out_valid   (out_valid),
    .out_item    (out_data)
  );

endmodule
